### rtl/ihb_pkg.sv
// shared types and constants of the ipv4 header builder
// no dependencies; used by every module of the block
`default_nettype none

package ihb_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned MAX_WORDS   = 7;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned RATE_W      = 20;
    localparam int unsigned SUM_W       = 20;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [3:0]  IP_VERSION  = 4'd4;
    localparam logic [3:0]  HLEN_BASE   = 4'd5;
    localparam logic [3:0]  HLEN_OPT    = 4'd7;
    localparam logic [7:0]  IP_TTL      = 8'd64;
    localparam logic [7:0]  OPT_LEN     = 8'd8;

    localparam logic [IDX_W-1:0] LAST_IDX_BASE = IDX_W'(4);
    localparam logic [IDX_W-1:0] LAST_IDX_OPT  = IDX_W'(6);

    localparam logic [31:0] RATE_MIN    = 32'd16;
    localparam logic [31:0] RATE_MAX    = 32'h1f << 15;

    // one finished header, words in wire order
    typedef struct packed {
        logic                              with_option;
        logic [MAX_WORDS-1:0][WORD_W-1:0]  words;
    } hdr_t;

endpackage

`default_nettype wire

### rtl/ipv4_rate_option_header_builder_top.sv
// top level of the ipv4 header builder with rate option and checksum
// depends on ihb_pkg, ihb_front, ihb_queue and ihb_back
`default_nettype none

// usage
//   s_ channel: one request per handshake, all header fields in parallel
//   m_ channel: one 32-bit header word per handshake, word_index 0 up,
//     last_word high on word 4 (plain header) or word 6 (with rate option)
//   cfg channel: writes the option type byte; cfg_ready is always high,
//     write only while no request is in flight
//   path: an accepted request passes the two front stages, then the queue
//     into the output register before its first word shows
//   throughput: one word per cycle while m_ready is high, set by the
//     single output word port; the front keeps accepting while the back
//     end drains, until the header queue and both front stages are full
//   reset: aresetn low at a clock edge empties the pipeline and queue and
//     clears the option byte to zero
//   stall: with m_ready low the current word holds; the queue and front
//     stages fill and then s_ready drops
module ipv4_rate_option_header_builder_top #(
    parameter int unsigned QUEUE_DEPTH = ihb_pkg::QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [7:0]             cfg_data,
    // request channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_with_option,
    input  wire logic [15:0]            s_total_length,
    input  wire logic [7:0]             s_protocol,
    input  wire logic [31:0]            s_src_addr,
    input  wire logic [31:0]            s_dst_addr,
    input  wire logic [1:0]             s_rate_op,
    input  wire logic [5:0]             s_rate_flags,
    input  wire logic [31:0]            s_req_rate,
    input  wire logic [31:0]            s_avail_rate,
    input  wire logic [23:0]            s_trace_id,
    // header word channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [31:0]                 m_header_word,
    output logic [2:0]                  m_word_index,
    output logic                        m_last_word
);

    logic [7:0]    option_code_reg;

    // front to queue
    logic          f_valid, f_ready;
    ihb_pkg::hdr_t f_hdr;
    // queue to back
    logic          q_valid, q_ready;
    ihb_pkg::hdr_t q_hdr;

    // option type register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            option_code_reg <= '0;
        end else if (cfg_valid) begin
            option_code_reg <= cfg_data;
        end
    end

    // classify and build: rate codes and checksum
    ihb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .option_code     (option_code_reg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_with_option  (s_with_option),
        .in_total_length (s_total_length),
        .in_protocol     (s_protocol),
        .in_src_addr     (s_src_addr),
        .in_dst_addr     (s_dst_addr),
        .in_rate_op      (s_rate_op),
        .in_rate_flags   (s_rate_flags),
        .in_req_rate     (s_req_rate),
        .in_avail_rate   (s_avail_rate),
        .in_trace_id     (s_trace_id),
        .out_valid       (f_valid),
        .out_ready       (f_ready),
        .out_hdr         (f_hdr)
    );

    // decouples front and back so each stalls on its own
    ihb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_hdr    (f_hdr),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_hdr   (q_hdr)
    );

    // word serializer and output register
    ihb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_hdr        (q_hdr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_header_word (m_header_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    // last word only at the end of a plain or optioned header
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_word) |->
            (m_word_index == ihb_pkg::LAST_IDX_BASE || m_word_index == ihb_pkg::LAST_IDX_OPT))
        else $error("last word at a wrong index");

    // words of one header follow in order
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=>
            (m_valid && m_word_index == $past(m_word_index) + 3'd1))
        else $error("header word sequence broken");

    // word 0 carries version 4 and a header length of 5 or 7 words
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word_index == 3'd0) |->
            (m_header_word[31:28] == ihb_pkg::IP_VERSION &&
             (m_header_word[27:24] == ihb_pkg::HLEN_BASE ||
              m_header_word[27:24] == ihb_pkg::HLEN_OPT)))
        else $error("bad first header word");

    // a finished header leaves the front only when the queue has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && !f_ready) |=> f_valid)
        else $error("front dropped a header");

endmodule

`default_nettype wire

### rtl/ihb_front.sv
// front end: takes requests, clamps and encodes rates, builds words and checksum
// two registered stages; depends on ihb_pkg
`default_nettype none

module ihb_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        option_code,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_with_option,
    input  wire logic [15:0]       in_total_length,
    input  wire logic [7:0]        in_protocol,
    input  wire logic [31:0]       in_src_addr,
    input  wire logic [31:0]       in_dst_addr,
    input  wire logic [1:0]        in_rate_op,
    input  wire logic [5:0]        in_rate_flags,
    input  wire logic [31:0]       in_req_rate,
    input  wire logic [31:0]       in_avail_rate,
    input  wire logic [23:0]       in_trace_id,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ihb_pkg::hdr_t          out_hdr
);

    typedef struct packed {
        logic                        with_option;
        logic [15:0]                 total_length;
        logic [7:0]                  protocol;
        logic [31:0]                 src_addr;
        logic [31:0]                 dst_addr;
        logic [1:0]                  rate_op;
        logic [5:0]                  rate_flags;
        logic [23:0]                 trace_id;
        logic [7:0]                  option_code;
        logic [ihb_pkg::RATE_W-1:0]  req_x;
        logic [3:0]                  req_sh;
        logic [ihb_pkg::RATE_W-1:0]  avail_x;
        logic [3:0]                  avail_sh;
        logic [ihb_pkg::SUM_W-1:0]   part_sum;
    } stage_a_t;

    function automatic logic [ihb_pkg::RATE_W-1:0] clamp_rate(input logic [31:0] raw);
        logic [31:0] v;
        v = raw;
        if (v < ihb_pkg::RATE_MIN) v = ihb_pkg::RATE_MIN;
        if (v > ihb_pkg::RATE_MAX) v = ihb_pkg::RATE_MAX;
        return v[ihb_pkg::RATE_W-1:0];
    endfunction

    // shift that brings the leading one to bit 4
    function automatic logic [3:0] lead_shift(input logic [ihb_pkg::RATE_W-1:0] x);
        logic [3:0] sh;
        sh = 4'd0;
        for (int b = 5; b < ihb_pkg::RATE_W; b++) begin
            if (x[b]) sh = 4'(b - 4);
        end
        return sh;
    endfunction

    // mini-float code, rounded up
    function automatic logic [7:0] rate_code(input logic [ihb_pkg::RATE_W-1:0] x,
                                             input logic [3:0] sh);
        logic [ihb_pkg::RATE_W-1:0] mask;
        logic [4:0]                 m;
        logic [4:0]                 m_up;
        logic [7:0]                 code;
        mask = (ihb_pkg::RATE_W'(1) << sh) - ihb_pkg::RATE_W'(1);
        m    = 5'(x >> sh);
        m_up = m + 5'd1;
        if ((x & mask) == '0) begin
            code = {m[3:0], sh};
        end else if (m != 5'h1f) begin
            code = {m_up[3:0], sh};
        end else begin
            code = {4'd0, sh + 4'd1};
        end
        return code;
    endfunction

    stage_a_t a_reg, a_next;
    logic     a_valid_reg;
    logic     b_valid_reg;
    ihb_pkg::hdr_t b_hdr_reg, b_hdr_next;
    logic     a_ready;
    logic     b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: clamp, leading-one search, partial checksum of known halves
    always_comb begin
        logic [3:0]  hlen;
        logic [15:0] opt_hi;
        hlen   = in_with_option ? ihb_pkg::HLEN_OPT : ihb_pkg::HLEN_BASE;
        opt_hi = {in_rate_op, in_rate_flags, 8'h00};
        a_next.with_option  = in_with_option;
        a_next.total_length = in_total_length;
        a_next.protocol     = in_protocol;
        a_next.src_addr     = in_src_addr;
        a_next.dst_addr     = in_dst_addr;
        a_next.rate_op      = in_rate_op;
        a_next.rate_flags   = in_rate_flags;
        a_next.trace_id     = in_trace_id;
        a_next.option_code  = option_code;
        a_next.req_x        = clamp_rate(in_req_rate);
        a_next.avail_x      = clamp_rate(in_avail_rate);
        a_next.req_sh       = lead_shift(a_next.req_x);
        a_next.avail_sh     = lead_shift(a_next.avail_x);
        a_next.part_sum     = ihb_pkg::SUM_W'({ihb_pkg::IP_VERSION, hlen, 8'h00})
                            + ihb_pkg::SUM_W'(in_total_length)
                            + ihb_pkg::SUM_W'({ihb_pkg::IP_TTL, in_protocol})
                            + ihb_pkg::SUM_W'(in_src_addr[31:16])
                            + ihb_pkg::SUM_W'(in_src_addr[15:0])
                            + ihb_pkg::SUM_W'(in_dst_addr[31:16])
                            + ihb_pkg::SUM_W'(in_dst_addr[15:0]);
        if (in_with_option) begin
            a_next.part_sum = a_next.part_sum
                            + ihb_pkg::SUM_W'({option_code, ihb_pkg::OPT_LEN})
                            + ihb_pkg::SUM_W'(opt_hi)
                            + ihb_pkg::SUM_W'(in_trace_id[23:16])
                            + ihb_pkg::SUM_W'(in_trace_id[15:0]);
        end
    end

    // stage b: rate codes, words, checksum fold
    always_comb begin
        logic [7:0]               rc;
        logic [7:0]               ac;
        logic [3:0]               hlen;
        logic [ihb_pkg::SUM_W-1:0] s;
        logic [16:0]              f;
        logic [15:0]              csum;
        rc   = rate_code(a_reg.req_x, a_reg.req_sh);
        ac   = rate_code(a_reg.avail_x, a_reg.avail_sh);
        hlen = a_reg.with_option ? ihb_pkg::HLEN_OPT : ihb_pkg::HLEN_BASE;
        s    = a_reg.part_sum;
        if (a_reg.with_option) begin
            s = s + ihb_pkg::SUM_W'(rc) + ihb_pkg::SUM_W'({ac, 8'h00});
        end
        f    = 17'(s[ihb_pkg::SUM_W-1:16]) + 17'(s[15:0]);
        csum = ~(f[15:0] + 16'(f[16]));
        b_hdr_next.with_option = a_reg.with_option;
        b_hdr_next.words[0] = {ihb_pkg::IP_VERSION, hlen, 8'h00, a_reg.total_length};
        b_hdr_next.words[1] = '0;
        b_hdr_next.words[2] = {ihb_pkg::IP_TTL, a_reg.protocol, csum};
        b_hdr_next.words[3] = a_reg.src_addr;
        b_hdr_next.words[4] = a_reg.dst_addr;
        b_hdr_next.words[5] = {a_reg.option_code, ihb_pkg::OPT_LEN,
                               a_reg.rate_op, a_reg.rate_flags, rc};
        b_hdr_next.words[6] = {ac, a_reg.trace_id};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) a_reg <= a_next;
        if (b_ready && a_valid_reg) b_hdr_reg <= b_hdr_next;
    end

    assign out_valid = b_valid_reg;
    assign out_hdr   = b_hdr_reg;

endmodule

`default_nettype wire

### rtl/ihb_queue.sv
// short header queue between the front and back ends
// depends on ihb_pkg for the header record
`default_nettype none

module ihb_queue #(
    parameter int unsigned DEPTH = ihb_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ihb_pkg::hdr_t  in_hdr,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ihb_pkg::hdr_t       out_hdr
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ihb_pkg::hdr_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_hdr   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop) count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_hdr;
    end

endmodule

`default_nettype wire

### rtl/ihb_back.sv
// back end: serializes one queued header into words, one per cycle while m_ready is high
// depends on ihb_pkg
`default_nettype none

module ihb_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire ihb_pkg::hdr_t             in_hdr,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ihb_pkg::WORD_W-1:0]     m_header_word,
    output logic [ihb_pkg::IDX_W-1:0]      m_word_index,
    output logic                           m_last_word
);

    ihb_pkg::hdr_t              hdr_reg;
    logic                       act_reg;
    logic [ihb_pkg::IDX_W-1:0]  idx_reg;
    logic                       last;
    logic                       load;

    assign last = idx_reg == (hdr_reg.with_option ? ihb_pkg::LAST_IDX_OPT
                                                  : ihb_pkg::LAST_IDX_BASE);
    // take the next header when idle or as the final word leaves
    assign in_ready = !act_reg || (m_ready && last);
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (load) begin
                act_reg <= 1'b1;
                idx_reg <= '0;
            end else if (act_reg && m_ready) begin
                if (last) begin
                    act_reg <= 1'b0;
                    idx_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + ihb_pkg::IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) hdr_reg <= in_hdr;
    end

    assign m_valid       = act_reg;
    assign m_header_word = hdr_reg.words[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = act_reg && last;

endmodule

`default_nettype wire

### verif/tb_top.sv
// self-checking testbench for ipv4_rate_option_header_builder_top
// depends on ihb_pkg and the rtl of the header builder, nothing else

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    // one header request as it sits on the s_ channel
    typedef struct packed {
        logic        with_option;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [1:0]  rate_op;
        logic [5:0]  rate_flags;
        logic [31:0] req_rate;
        logic [31:0] avail_rate;
        logic [23:0] trace_id;
    } hdr_req_t;

    // one header word as it should show on the m_ channel
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } hdr_word_t;

    // clock, reset and every block input start at known values
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data       = 8'h00;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_with_option  = 1'b0;
    logic [15:0] s_total_length = '0;
    logic [7:0]  s_protocol     = '0;
    logic [31:0] s_src_addr     = '0;
    logic [31:0] s_dst_addr     = '0;
    logic [1:0]  s_rate_op      = '0;
    logic [5:0]  s_rate_flags   = '0;
    logic [31:0] s_req_rate     = '0;
    logic [31:0] s_avail_rate   = '0;
    logic [23:0] s_trace_id     = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_header_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    // requests waiting to be driven, and header words still owed by the block
    hdr_req_t  pending_reqs[$];
    hdr_word_t words_due[$];
    hdr_req_t  req_on_bus;

    // local copy of the option type byte
    logic [7:0] opt_type_byte = 8'h00;

    int reqs_queued    = 0;
    int reqs_taken     = 0;
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    ipv4_rate_option_header_builder_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_with_option  (s_with_option),
        .s_total_length (s_total_length),
        .s_protocol     (s_protocol),
        .s_src_addr     (s_src_addr),
        .s_dst_addr     (s_dst_addr),
        .s_rate_op      (s_rate_op),
        .s_rate_flags   (s_rate_flags),
        .s_req_rate     (s_req_rate),
        .s_avail_rate   (s_avail_rate),
        .s_trace_id     (s_trace_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_header_word  (m_header_word),
        .m_word_index   (m_word_index),
        .m_last_word    (m_last_word)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mini-float rate code: clamp, then round up to (16 + m) << e, hidden bit dropped
    function automatic logic [7:0] rate_to_code(input logic [31:0] rate);
        logic [19:0] clamped;
        int          msb;
        logic [4:0]  mant;
        logic [3:0]  expo;
        if (rate < ihb_pkg::RATE_MIN) begin
            clamped = 20'd16;
        end else if (rate > ihb_pkg::RATE_MAX) begin
            clamped = ihb_pkg::RATE_MAX[19:0];
        end else begin
            clamped = rate[19:0];
        end
        msb = 4;
        for (int b = 4; b < 20; b++) begin
            if (clamped[b]) msb = b;
        end
        expo = 4'(msb - 4);
        mant = 5'(clamped >> expo);
        // lost bits below the mantissa mean round up
        if ((20'(mant) << expo) != clamped) begin
            if (mant == 5'h1f) begin
                // carry out of the mantissa: hidden bit only, one step up in exponent
                mant = 5'h10;
                expo = expo + 4'd1;
            end else begin
                mant = mant + 5'd1;
            end
        end
        return {mant[3:0], expo};
    endfunction

    // lay out the header for one request and queue its words with their checksum
    function automatic void queue_header_words(input hdr_req_t r);
        logic [31:0] w[7];
        logic [31:0] sum;
        int          n_words;
        hdr_word_t   hw;
        n_words = r.with_option ? 7 : 5;
        w[0] = {ihb_pkg::IP_VERSION, r.with_option ? ihb_pkg::HLEN_OPT : ihb_pkg::HLEN_BASE,
                8'h00, r.total_length};
        w[1] = 32'h0;
        w[2] = {ihb_pkg::IP_TTL, r.protocol, 16'h0000};
        w[3] = r.src_addr;
        w[4] = r.dst_addr;
        w[5] = 32'h0;
        w[6] = 32'h0;
        if (r.with_option) begin
            w[5] = {opt_type_byte, ihb_pkg::OPT_LEN, r.rate_op, r.rate_flags,
                    rate_to_code(r.req_rate)};
            w[6] = {rate_to_code(r.avail_rate), r.trace_id};
        end
        sum = 32'h0;
        for (int k = 0; k < n_words; k++) begin
            sum = sum + {16'h0, w[k][31:16]} + {16'h0, w[k][15:0]};
        end
        // fold twice, then invert into the low half of word 2
        sum = {16'h0, sum[31:16]} + {16'h0, sum[15:0]};
        sum = sum + {16'h0, sum[31:16]};
        w[2][15:0] = ~sum[15:0];
        for (int k = 0; k < n_words; k++) begin
            hw.word  = w[k];
            hw.index = 3'(k);
            hw.last  = (k == n_words - 1);
            words_due.push_back(hw);
        end
    endfunction

    // rates spread over the clamp edges, exact codes, rounding edges and raw bits
    function automatic logic [31:0] pick_rate();
        logic [31:0] r;
        case ($urandom_range(6))
            0: r = $urandom;
            1: r = $urandom_range(40);
            2: r = $urandom_range(1015808 + 64, 1015808 - 64);
            3: r = $urandom_range(1015808, 16);
            4: r = ((32'd16 + $urandom_range(15)) << $urandom_range(15))
                   + $urandom_range(2) - 1;
            5: r = 32'd1 << $urandom_range(31);
            default: r = ~(32'd1 << $urandom_range(31));
        endcase
        return r;
    endfunction

    function automatic hdr_req_t random_req();
        hdr_req_t r;
        r.with_option  = ($urandom_range(3) != 0);
        r.total_length = $urandom;
        r.protocol     = $urandom;
        r.src_addr     = $urandom;
        r.dst_addr     = $urandom;
        r.rate_op      = $urandom;
        r.rate_flags   = $urandom;
        r.req_rate     = pick_rate();
        r.avail_rate   = pick_rate();
        r.trace_id     = $urandom;
        return r;
    endfunction

    task automatic add_req(input hdr_req_t r);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic add_random_reqs(input int count);
        for (int i = 0; i < count; i++) add_req(random_req());
    endtask

    // wait until every queued request went in and every word came out
    task automatic wait_drained();
        while (reqs_taken != reqs_queued || words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // option byte write, only called with the block idle
    task automatic write_option_byte(input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        opt_type_byte = value;
        cfg_valid <= 1'b0;
    endtask

    // request driver: predicts on acceptance, then loads the next request or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                queue_header_words(req_on_bus);
                reqs_taken++;
            end
            // channel free after this edge: decide on the next request
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_on_bus     = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_with_option  <= req_on_bus.with_option;
                    s_total_length <= req_on_bus.total_length;
                    s_protocol     <= req_on_bus.protocol;
                    s_src_addr     <= req_on_bus.src_addr;
                    s_dst_addr     <= req_on_bus.dst_addr;
                    s_rate_op      <= req_on_bus.rate_op;
                    s_rate_flags   <= req_on_bus.rate_flags;
                    s_req_rate     <= req_on_bus.req_rate;
                    s_avail_rate   <= req_on_bus.avail_rate;
                    s_trace_id     <= req_on_bus.trace_id;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // word monitor: compares every accepted word with the oldest one due
    always @(posedge aclk) begin
        hdr_word_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    $display("%0t: unexpected header word, expected none, got %h idx %0d last %0b",
                             $time, m_header_word, m_word_index, m_last_word);
                    mismatches++;
                end else begin
                    exp_w = words_due.pop_front();
                    if (m_header_word !== exp_w.word) begin
                        $display("%0t: header_word mismatch at idx %0d, expected %h, got %h",
                                 $time, exp_w.index, exp_w.word, m_header_word);
                        mismatches++;
                    end
                    if (m_word_index !== exp_w.index) begin
                        $display("%0t: word_index mismatch, expected %0d, got %0d",
                                 $time, exp_w.index, m_word_index);
                        mismatches++;
                    end
                    if (m_last_word !== exp_w.last) begin
                        $display("%0t: last_word mismatch at idx %0d, expected %0b, got %0b",
                                 $time, exp_w.index, exp_w.last, m_last_word);
                        mismatches++;
                    end
                end
            end
            // back-pressure drawn fresh every cycle
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: too long with no handshake on any channel ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words still due", $time, words_due.size());
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        hdr_req_t base;
        hdr_req_t r;

        // synchronous reset held low at the start, then released
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase 1: directed requests, option byte at its top value, no idling
        write_option_byte(8'hff);
        base = '{with_option: 1'b1, total_length: 16'h0014, protocol: 8'h06,
                 src_addr: 32'h0a000001, dst_addr: 32'hc0a80001, rate_op: 2'd0,
                 rate_flags: 6'h00, req_rate: 32'd1000, avail_rate: 32'd2000,
                 trace_id: 24'h000000};
        // plain five-word header
        r = base; r.with_option = 1'b0; add_req(r);
        // all fields zero, with and without the option
        r = '0; add_req(r);
        r.with_option = 1'b1; add_req(r);
        // all fields ones, with and without the option
        r = '1; r.with_option = 1'b0; add_req(r);
        r = '1; add_req(r);
        // op codes 0 to 2, rates around the low clamp and exact steps
        r = base; r.rate_op = 2'd0; r.req_rate = 32'd15; r.avail_rate = 32'd16; add_req(r);
        r = base; r.rate_op = 2'd1; r.req_rate = 32'd17; r.avail_rate = 32'd31; add_req(r);
        r = base; r.rate_op = 2'd2; r.req_rate = 32'd32; r.avail_rate = 32'd33; add_req(r);
        // rounding that carries out of the mantissa
        r = base; r.rate_op = 2'd3; r.req_rate = 32'd63; r.avail_rate = 32'd62; add_req(r);
        // around the high clamp
        r = base; r.req_rate = 32'd1015807; r.avail_rate = 32'd1015808; add_req(r);
        r = base; r.req_rate = 32'd1015809; r.avail_rate = 32'h80000000; add_req(r);
        // exact power of two and one above it
        r = base; r.req_rate = 32'd1; r.avail_rate = 32'd524288; add_req(r);
        r = base; r.req_rate = 32'd524289; r.avail_rate = 32'd1015807;
        r.rate_flags = 6'h2a; r.trace_id = 24'h5a5a5a; add_req(r);
        add_random_reqs(12);
        wait_drained();

        // phase 2: option byte zero, sender mostly idle
        write_option_byte(8'h00);
        send_idle_pct  = 68;
        recv_stall_pct = 0;
        add_random_reqs(25);
        wait_drained();

        // phase 3: mid option byte, receiver mostly stalled
        write_option_byte(8'($urandom_range(254, 1)));
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        add_random_reqs(25);
        wait_drained();

        // phase 4: light idling on both sides, sender pauses halfway until drained
        write_option_byte(8'($urandom));
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        add_random_reqs(13);
        wait_drained();
        add_random_reqs(13);
        wait_drained();

        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### ipv4_rate_option_header_builder_top.f
rtl/ihb_pkg.sv
rtl/ihb_front.sv
rtl/ihb_queue.sv
rtl/ihb_back.sv
rtl/ipv4_rate_option_header_builder_top.sv
verif/tb_top.sv
